@@ sv/uri_percent_encoder_assert.svh @@
// Assertion macros for the URI percent encoder checker.
// No dependencies; included by the checker file only.
`ifndef URI_PERCENT_ENCODER_ASSERT_SVH
`define URI_PERCENT_ENCODER_ASSERT_SVH

// Clocked property, masked while reset is asserted.
`define UPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked property that also holds during reset.
`define UPE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ sv/upe_pkg.sv @@
// Shared types, constants and helper functions for the URI percent encoder.
// No dependencies; imported by every RTL module of the block.
package upe_pkg;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned CharW    = 7;
  localparam int unsigned AddrW    = 3;
  localparam int unsigned FifoDepth = 2;

  // Register index, taken from paddr[2]
  localparam logic RegEscapeReserved = 1'b0;

  localparam logic [CharW-1:0] CharPct = 7'h25;

  // One unit of work handed from the front to the back
  typedef struct packed {
    logic             literal;  // single character, no escaping
    logic [CharW-1:0] ch;
    logic [1:0]       n_m1;     // octet count minus one
    logic [3:0][7:0]  oct;      // octet 0 is sent first
    logic             last;     // string end
  } job_t;

  function automatic logic [CharW-1:0] hex_char(logic [3:0] nib);
    logic [CharW-1:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

  function automatic logic needs_escape(logic [CharW-1:0] c, logic esc_res);
    logic excl;
    logic resv;
    excl = 1'b0;
    resv = 1'b0;
    unique case (c)
      7'h20, 7'h22, 7'h23, 7'h25, 7'h3C, 7'h3E,
      7'h5C, 7'h5E, 7'h60, 7'h7B, 7'h7C, 7'h7D: excl = 1'b1;
      7'h24, 7'h26, 7'h2B, 7'h2C, 7'h2F, 7'h3A,
      7'h3B, 7'h3D, 7'h3F, 7'h40, 7'h5B, 7'h5D: resv = 1'b1;
      default: ;
    endcase
    return (c < 7'h20) || (c == 7'h7F) || excl || (resv && esc_res);
  endfunction

endpackage

@@ sv/upe_front.sv @@
// Front end: accepts code units, pairs surrogates and builds octet jobs.
// Depends on upe_pkg.
module upe_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     esc_res_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [upe_pkg::UnitW-1:0] unit_i,
  input  logic                     end_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output upe_pkg::job_t            job_o
);
  import upe_pkg::*;

  logic       pend_q, pend_d;
  logic [9:0] hbits_q, hbits_d;
  logic       accept;
  logic       is_high;
  logic       hold;
  logic [10:0] h;
  logic [9:0]  hi10, lo10;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_high    = (unit_i[15:10] == 6'b110110);
  assign hold       = !pend_q && is_high && !end_i;
  assign push_o     = accept && !hold;

  assign hi10 = pend_q ? hbits_q : unit_i[9:0];
  assign lo10 = pend_q ? unit_i[9:0] : 10'd0;
  assign h    = {1'b0, hi10} + 11'h040;

  always_comb begin
    job_o         = '0;
    job_o.ch      = unit_i[6:0];
    job_o.last    = end_i;
    if (pend_q || is_high) begin
      job_o.n_m1   = 2'd3;
      job_o.oct[0] = {5'b11110, h[10:8]};
      job_o.oct[1] = {2'b10, h[7:2]};
      job_o.oct[2] = {2'b10, h[1:0], lo10[9:6]};
      job_o.oct[3] = {2'b10, lo10[5:0]};
    end else if (unit_i[15:7] == '0) begin
      job_o.literal = !needs_escape(unit_i[6:0], esc_res_i);
      job_o.n_m1    = 2'd0;
      job_o.oct[0]  = unit_i[7:0];
    end else if (unit_i[15:11] == '0) begin
      job_o.n_m1   = 2'd1;
      job_o.oct[0] = {3'b110, unit_i[10:6]};
      job_o.oct[1] = {2'b10, unit_i[5:0]};
    end else begin
      job_o.n_m1   = 2'd2;
      job_o.oct[0] = {4'b1110, unit_i[15:12]};
      job_o.oct[1] = {2'b10, unit_i[11:6]};
      job_o.oct[2] = {2'b10, unit_i[5:0]};
    end
  end

  always_comb begin
    pend_d  = pend_q;
    hbits_d = hbits_q;
    if (accept) begin
      if (hold) begin
        pend_d  = 1'b1;
        hbits_d = unit_i[9:0];
      end else begin
        pend_d  = 1'b0;
        hbits_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= 1'b0;
      hbits_q <= '0;
    end else begin
      pend_q  <= pend_d;
      hbits_q <= hbits_d;
    end
  end

endmodule

@@ sv/upe_fifo.sv @@
// Short job queue between the front and back ends.
// Depends on upe_pkg for the job type and depth.
module upe_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  upe_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output upe_pkg::job_t rdata_o
);
  import upe_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(FifoDepth);

  job_t            mem_q [FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrMax) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrMax) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

@@ sv/upe_back.sv @@
// Back end: walks each job into characters, "%HH" per octet, into an output register.
// Depends on upe_pkg.
module upe_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  input  upe_pkg::job_t            job_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [upe_pkg::CharW-1:0] out_char_o,
  output logic                     run_last_o,
  output logic                     text_last_o
);
  import upe_pkg::*;

  typedef enum logic [1:0] {
    PhPct,
    PhHi,
    PhLo
  } phase_e;

  phase_e           ph_q;
  logic [1:0]       oct_q;
  logic             vld_q;
  logic [CharW-1:0] char_q;
  logic             rl_q, tl_q;

  logic             adv;
  logic             last_char;
  logic [7:0]       octet;
  logic [CharW-1:0] ch;

  assign octet     = job_i.oct[oct_q];
  assign adv       = job_valid_i && (!vld_q || out_ready_i);
  assign last_char = job_i.literal || ((ph_q == PhLo) && (oct_q == job_i.n_m1));
  assign pop_o     = adv && last_char;

  always_comb begin
    if (job_i.literal) begin
      ch = job_i.ch;
    end else begin
      unique case (ph_q)
        PhPct:   ch = CharPct;
        PhHi:    ch = hex_char(octet[7:4]);
        PhLo:    ch = hex_char(octet[3:0]);
        default: ch = CharPct;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PhPct;
      oct_q  <= '0;
      vld_q  <= 1'b0;
      char_q <= '0;
      rl_q   <= 1'b0;
      tl_q   <= 1'b0;
    end else if (adv) begin
      vld_q  <= 1'b1;
      char_q <= ch;
      rl_q   <= last_char;
      tl_q   <= last_char && job_i.last;
      if (last_char) begin
        ph_q  <= PhPct;
        oct_q <= '0;
      end else begin
        unique case (ph_q)
          PhPct:   ph_q <= PhHi;
          PhHi:    ph_q <= PhLo;
          PhLo: begin
            ph_q  <= PhPct;
            oct_q <= oct_q + 2'd1;
          end
          default: ph_q <= PhPct;
        endcase
      end
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  assign out_valid_o = vld_q;
  assign out_char_o  = char_q;
  assign run_last_o  = rl_q;
  assign text_last_o = tl_q;

endmodule

@@ sv/uri_percent_encoder.sv @@
// Top level of the URI percent encoder: config register, front end, job queue, back end.
// Depends on upe_pkg, upe_front, upe_fifo and upe_back.
//
//  channel  | dir | handshake              | payload
//  s_axis   | in  | tvalid/tready          | tdata[15:0] code_unit, tlast string_end
//  m_axis   | out | tvalid/tready          | tdata[6:0] out_char, tuser run_last,
//           |     |                        | tlast text_last
//  apb      | in  | psel/penable/pready    | reg 0 @ 0x0: escape_reserved
//
// The back end emits one character per cycle while m_axis_tready allows: a literal unit
// is one character, each escaped octet three ("%HH"), so a unit yields 1, 3, 6, 9 or 12
// characters (a held high surrogate emits nothing). A two-entry job queue lets the front
// take units while the back drains; s_axis_tready drops only when the queue is full.
// Reset clears the held surrogate, the queue and the output register.
module uri_percent_encoder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // stream in
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [15:0]               s_axis_tdata,  // [15:0] code_unit
  input  logic                      s_axis_tlast,
  // stream out
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // [6:0] out_char, [7] zero
  output logic                      m_axis_tuser,  // [0] run_last
  output logic                      m_axis_tlast,
  // config
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [upe_pkg::AddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import upe_pkg::*;

  logic             esc_res_q;
  logic             q_full, push, pop, job_valid;
  job_t             wjob, rjob;
  logic [CharW-1:0] out_char;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegEscapeReserved) ? {31'd0, esc_res_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_res_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegEscapeReserved)) begin
      esc_res_q <= pwdata[0];
    end
  end

  upe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .esc_res_i  (esc_res_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .unit_i     (s_axis_tdata),
    .end_i      (s_axis_tlast),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (wjob)
  );

  upe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wjob),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (rjob)
  );

  upe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (rjob),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .run_last_o  (m_axis_tuser),
    .text_last_o (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule

@@ sv/upe_checker.sv @@
// Port-level checks for the URI percent encoder, bound to the top level.
// Depends on uri_percent_encoder_assert.svh.
`include "uri_percent_encoder_assert.svh"

module upe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast,
  input logic       pready
);

  // stalled beat holds
  `UPE_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "output beat changed while stalled")

  // end of string is always the end of a run
  `UPE_ASSERT(a_text_in_run, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser, "text_last without run_last")

  // '%' only opens an escape, never closes a run
  `UPE_ASSERT(a_pct_not_last, m_axis_tvalid && (m_axis_tdata == 8'h25) |-> !m_axis_tuser, "percent sign ends a run")

  `UPE_ASSERT_ALWAYS(a_pready, pready, "pready low")

endmodule

bind uri_percent_encoder upe_checker u_upe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .pready        (pready)
);

@@ verif/uri_percent_encoder_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the URI percent encoder: predicts the characters of every input beat and
// compares them with the output stream. Depends on upe_pkg for the register index.
module uri_percent_encoder_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_tvalid_i,
  input  logic                      s_tready_i,
  input  logic [15:0]               s_tdata_i,   // [15:0] code_unit
  input  logic                      s_tlast_i,   // string_end
  input  logic                      m_tvalid_i,
  input  logic                      m_tready_i,
  input  logic [7:0]                m_tdata_i,   // [6:0] out_char
  input  logic                      m_tuser_i,   // [0] run_last
  input  logic                      m_tlast_i,   // text_last
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [upe_pkg::AddrW-1:0] paddr_i,
  input  logic [31:0]               pwdata_i,
  output int unsigned               err_cnt_o,
  output int unsigned               pending_o
);

  typedef struct packed {
    logic [6:0] ch;
    logic       run_last;
    logic       text_last;
  } uri_char_t;

  uri_char_t   char_q[$];
  logic        esc_reserved;
  logic        high_held;
  logic [9:0]  high_low10;
  int unsigned err_cnt;

  function automatic logic [6:0] hex_ascii(logic [3:0] nib);
    logic [6:0] c;
    if (nib < 4'd10) begin
      c = 7'h30 + {3'b000, nib};
    end else begin
      c = 7'h37 + {3'b000, nib};
    end
    return c;
  endfunction

  function automatic logic in_char_set(string set, logic [6:0] c);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < set.len(); k++) begin
      if (set[k] == {1'b0, c}) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  task automatic push_char(logic [6:0] c);
    uri_char_t e;
    e.ch        = c;
    e.run_last  = 1'b0;
    e.text_last = 1'b0;
    char_q.push_back(e);
  endtask

  task automatic push_octet(logic [7:0] o);
    push_char(7'h25);  // '%'
    push_char(hex_ascii(o[7:4]));
    push_char(hex_ascii(o[3:0]));
  endtask

  // four octets of the supplementary code point rebuilt from both halves
  task automatic push_pair(logic [9:0] hi10, logic [9:0] lo10);
    logic [20:0] cp;
    cp = 21'h10000 + {1'b0, hi10, lo10};
    push_octet({5'b11110, cp[20:18]});
    push_octet({2'b10, cp[17:12]});
    push_octet({2'b10, cp[11:6]});
    push_octet({2'b10, cp[5:0]});
  endtask

  task automatic encode_unit(logic [15:0] cu, logic str_end);
    int unsigned start_sz;
    uri_char_t   tail;
    start_sz = char_q.size();
    if (high_held) begin
      push_pair(high_low10, cu[9:0]);
      high_held  = 1'b0;
      high_low10 = '0;
    end else if (cu <= 16'h007F) begin
      if (cu < 16'h0020 || cu == 16'h007F || in_char_set(" \"#%<>\\^`{|}", cu[6:0]) ||
          (esc_reserved && in_char_set("$&+,/:;=?@[]", cu[6:0]))) begin
        push_octet(cu[7:0]);
      end else begin
        push_char(cu[6:0]);
      end
    end else if (cu <= 16'h07FF) begin
      push_octet({3'b110, cu[10:6]});
      push_octet({2'b10, cu[5:0]});
    end else if (cu[15:10] == 6'b110110) begin
      // high half: flushed with a zero low half at string end, else held
      if (str_end) begin
        push_pair(cu[9:0], 10'd0);
      end else begin
        high_held  = 1'b1;
        high_low10 = cu[9:0];
      end
    end else begin
      push_octet({4'b1110, cu[15:12]});
      push_octet({2'b10, cu[11:6]});
      push_octet({2'b10, cu[5:0]});
    end
    if (char_q.size() > start_sz) begin
      tail           = char_q.pop_back();
      tail.run_last  = 1'b1;
      tail.text_last = str_end;
      char_q.push_back(tail);
    end
    if (str_end) begin
      high_held  = 1'b0;
      high_low10 = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    uri_char_t want;
    if (!rst_ni) begin
      char_q.delete();
      esc_reserved = 1'b0;
      high_held    = 1'b0;
      high_low10   = '0;
      err_cnt      = 0;
      err_cnt_o   <= 0;
      pending_o   <= 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[2] == upe_pkg::RegEscapeReserved) begin
        esc_reserved = pwdata_i[0];
      end
      // expectations first, so a same-cycle result still finds its entry
      if (s_tvalid_i && s_tready_i) begin
        encode_unit(s_tdata_i, s_tlast_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (char_q.size() == 0) begin
          $error("unexpected beat: out_char %h run_last %b text_last %b",
                 m_tdata_i[6:0], m_tuser_i, m_tlast_i);
          err_cnt++;
        end else begin
          want = char_q.pop_front();
          if (m_tdata_i[6:0] !== want.ch) begin
            $error("out_char: expected %h, got %h", want.ch, m_tdata_i[6:0]);
            err_cnt++;
          end
          if (m_tuser_i !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_tuser_i);
            err_cnt++;
          end
          if (m_tlast_i !== want.text_last) begin
            $error("text_last: expected %b, got %b", want.text_last, m_tlast_i);
            err_cnt++;
          end
        end
      end
      err_cnt_o <= err_cnt;
      pending_o <= char_q.size();
    end
  end

endmodule

@@ verif/uri_percent_encoder_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the URI percent encoder: clock, reset, stream and APB stimulus, verdict.
// Depends on upe_pkg, the encoder RTL and uri_percent_encoder_checker.
module uri_percent_encoder_tb;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      s_axis_tvalid;
  logic                      s_axis_tready;
  logic [15:0]               s_axis_tdata;   // [15:0] code_unit
  logic                      s_axis_tlast;
  logic                      m_axis_tvalid;
  logic                      m_axis_tready;
  logic [7:0]                m_axis_tdata;   // [6:0] out_char, [7] zero
  logic                      m_axis_tuser;   // [0] run_last
  logic                      m_axis_tlast;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [upe_pkg::AddrW-1:0] paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;
  int unsigned               err_cnt;
  int unsigned               pending;
  logic                      idle_en;
  int unsigned               stall_left;

  always #4 clk_i = ~clk_i;

  uri_percent_encoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  uri_percent_encoder_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_i (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .m_tvalid_i (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_i  (m_axis_tdata),
    .m_tuser_i  (m_axis_tuser),
    .m_tlast_i  (m_axis_tlast),
    .psel_i     (psel),
    .penable_i  (penable),
    .pwrite_i   (pwrite),
    .pready_i   (pready),
    .paddr_i    (paddr),
    .pwdata_i   (pwdata),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  task automatic send_unit(input logic [15:0] unit, input logic str_end);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= unit;
    s_axis_tlast  <= str_end;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // wait out every expected character, then let a trailing held surrogate settle;
  // the pending count is registered, so it lags the last accepted beat
  task automatic drain_output();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_escape_reserved(input logic value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {upe_pkg::RegEscapeReserved, 2'b00};
    pwdata  <= {31'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_random(input int unsigned count, input logic allow_idle);
    int unsigned sent;
    int unsigned next_switch;
    int unsigned pick;
    logic        str_end;
    sent        = 0;
    next_switch = 0;
    while (sent < count) begin
      // alternate stretches with and without idling
      if (sent >= next_switch) begin
        idle_en     = allow_idle && ($urandom_range(0, 3) != 0);
        next_switch = sent + 30;
      end
      pick    = $urandom_range(0, 99);
      str_end = ($urandom_range(0, 7) == 0);
      if (pick < 35) begin
        send_unit(16'($urandom_range(16'h20, 16'h7E)), str_end);
      end else if (pick < 45) begin
        send_unit($urandom_range(0, 1) ? 16'h007F : 16'($urandom_range(0, 16'h1F)), str_end);
      end else if (pick < 60) begin
        send_unit(16'($urandom_range(16'h80, 16'h7FF)), str_end);
      end else if (pick < 75) begin
        send_unit(16'($urandom_range(16'h800, 16'hFFFF)), str_end);
      end else if (pick < 92) begin
        // well-formed surrogate pair
        send_unit({6'b110110, 10'($urandom_range(0, 1023))}, 1'b0);
        send_unit({6'b110111, 10'($urandom_range(0, 1023))}, str_end);
        sent++;
      end else begin
        send_unit(16'($urandom_range(0, 16'hFFFF)), str_end);
      end
      sent++;
    end
  endtask

  // output side back-pressure
  initial begin
    m_axis_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (stall_left != 0) begin
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    idle_en        = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_escape_reserved(1'b1);
    send_unit(16'h0000, 1'b0);
    send_unit(16'h001F, 1'b0);
    send_unit(16'h0020, 1'b0);
    send_unit(16'h0021, 1'b0);
    send_unit(16'h0024, 1'b0);  // reserved, escaped here
    send_unit(16'h005D, 1'b0);
    send_unit(16'h007E, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b0);
    send_unit(16'hDC00, 1'b0);  // lone low half
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBC0, 1'b0);  // plane 16
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    send_unit(16'hD801, 1'b0);  // held half followed by plain ASCII
    send_unit(16'h0041, 1'b0);
    send_unit(16'hDABC, 1'b1);  // high half at string end
    send_unit(16'h0041, 1'b1);
    drain_output();

    write_escape_reserved(1'b0);
    send_random(140, 1'b1);
    drain_output();

    write_escape_reserved(1'b1);
    send_random(140, 1'b1);
    drain_output();

    write_escape_reserved(1'b0);
    idle_en = 1'b0;
    send_random(140, 1'b0);
    drain_output();
    repeat (20) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
